[rtl/bse_pkg.sv]
// Shared types, codes and helper functions for the spaced bitmap expander.
// Used by every module in rtl; depends on nothing.
package bse_pkg;

   localparam int unsigned ROWS_PER_WORD = 64;
   localparam int unsigned IDX_W         = $clog2(ROWS_PER_WORD);
   localparam int unsigned ROW_W         = 31;
   localparam int unsigned BASE_W        = 32;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned REQ_DATA_W    = 96;
   localparam int unsigned RSP_DATA_W    = 96;
   localparam int unsigned RSP_USER_W    = 3;

   typedef enum logic {
      KIND_WORD  = 1'b0,
      KIND_VALUE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_BIT  = 2'd1,
      ST_BEYOND  = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic [ROWS_PER_WORD-1:0]   mask_word;
      logic [VALUE_W-1:0]         value;
   } req_type;

   typedef struct packed {
      logic                 write_valid;
      logic [ROW_W-1:0]     position;
      logic [VALUE_W-1:0]   data;
      logic                 need_word;
      logic [ROW_W-1:0]     values_used;
      status_type           status;
   } rsp_type;

   // Index of the lowest set bit: isolate it, then OR in the index of each hit.
   function automatic logic [IDX_W-1:0] lowest_index(input logic [ROWS_PER_WORD-1:0] w);
      logic [ROWS_PER_WORD-1:0] iso;
      logic [IDX_W-1:0]         idx;
      iso = w & (~w + {{(ROWS_PER_WORD-1){1'b0}}, 1'b1});
      idx = '0;
      for (int i = 0; i < ROWS_PER_WORD; i++) begin
         if (iso[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/bse_req_stage.sv]
// Input register of the spaced bitmap expander: captures one request.
// Depends on bse_pkg.
module bse_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bse_pkg::req_type req_in,
   input  logic             drain,
   output logic             valid,
   output bse_pkg::req_type req_out
);
   import bse_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff,   req_in_d;

   // Hold until drained, load when a new request arrives
   always_comb begin
      valid_in = load | (valid_ff & ~drain);
      req_in_d = load ? req_in : req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in_d;
   end

   assign valid   = valid_ff;
   assign req_out = req_ff;

endmodule

[rtl/bse_step.sv]
// Run state and step logic of the spaced bitmap expander.
// Depends on bse_pkg.
module bse_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  bse_pkg::req_type        req,
   input  logic                    csr_write,
   input  logic [bse_pkg::ROW_W-1:0] csr_value,
   output bse_pkg::rsp_type        rsp
);
   import bse_pkg::*;

   logic [ROW_W-1:0]         total_ff,   total_in;
   logic [ROWS_PER_WORD-1:0] pending_ff, pending_in;
   logic [ROW_W-1:0]         word_base_ff, word_base_in;
   logic [BASE_W-1:0]        next_base_ff, next_base_in;
   logic [ROW_W-1:0]         placed_ff,  placed_in;

   logic                     beyond;
   logic [BASE_W-1:0]        left;
   logic [ROWS_PER_WORD-1:0] keep_mask;
   logic [ROWS_PER_WORD-1:0] word_masked;
   logic [IDX_W-1:0]         idx;
   logic [ROW_W-1:0]         pos;

   // Word range check and tail mask
   always_comb begin
      beyond      = next_base_ff >= {1'b0, total_ff};
      left        = {1'b0, total_ff} - next_base_ff;
      keep_mask   = (left < BASE_W'(ROWS_PER_WORD)) ? ~({ROWS_PER_WORD{1'b1}} << left[IDX_W-1:0])
                                                    : {ROWS_PER_WORD{1'b1}};
      word_masked = req.mask_word & keep_mask;
      idx         = lowest_index(pending_ff);
      pos         = word_base_ff + ROW_W'(idx);
   end

   // Advance the run state and form the result
   always_comb begin
      total_in     = total_ff;
      pending_in   = pending_ff;
      word_base_in = word_base_ff;
      next_base_in = next_base_ff;
      placed_in    = placed_ff;
      rsp          = '0;
      rsp.status   = ST_OK;
      if (req.kind == KIND_WORD) begin
         if (beyond) begin
            rsp.status = ST_BEYOND;
         end else begin
            if (pending_ff != '0) begin
               rsp.status = ST_DROPPED;
            end
            pending_in   = word_masked;
            word_base_in = next_base_ff[ROW_W-1:0];
            next_base_in = next_base_ff + BASE_W'(ROWS_PER_WORD);
         end
      end else begin
         if (pending_ff == '0) begin
            rsp.status = ST_NO_BIT;
         end else begin
            rsp.write_valid = 1'b1;
            rsp.position    = pos;
            rsp.data        = req.value;
            pending_in      = pending_ff & (pending_ff - {{(ROWS_PER_WORD-1){1'b0}}, 1'b1});
            placed_in       = placed_ff + {{(ROW_W-1){1'b0}}, 1'b1};
         end
      end
      rsp.need_word   = (pending_in == '0);
      rsp.values_used = placed_in;
      // Drop the step and restart the run on a register write
      if (!fire) begin
         pending_in   = pending_ff;
         word_base_in = word_base_ff;
         next_base_in = next_base_ff;
         placed_in    = placed_ff;
      end
      if (csr_write) begin
         total_in     = csr_value;
         pending_in   = '0;
         word_base_in = '0;
         next_base_in = '0;
         placed_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         pending_ff   <= '0;
         word_base_ff <= '0;
         next_base_ff <= '0;
         placed_ff    <= '0;
      end else begin
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         word_base_ff <= word_base_in;
         next_base_ff <= next_base_in;
         placed_ff    <= placed_in;
      end
   end

   // A word past the end leaves the run untouched
   assert property (@(posedge clock) disable iff (reset)
      fire && !csr_write && rsp.status == ST_BEYOND |=> $stable(pending_ff) && $stable(next_base_ff))
      else $error("word beyond length changed run state");

   // Placed count moves only with a scatter write
   assert property (@(posedge clock) disable iff (reset)
      !csr_write && !(fire && rsp.write_valid) |=> $stable(placed_ff))
      else $error("placed count moved without a write");

endmodule

[rtl/bitmap_spaced_expand_top.sv]
// Top level of the spaced bitmap expander: stream ports, result register.
// Depends on bse_pkg, bse_req_stage and bse_step.
//
// Takes one request per cycle unless the response side stalls: a 64-bit bitmap word or
// a dense 32-bit value, and returns exactly one response per request, through the input
// register and then the result register. The rate of one request per cycle is set by
// the run-state loop in bse_step: a 64-bit lowest-set-bit encode, the bit
// clear and the base-row add close with no register between them. Writing total_bits on
// the csr port restarts the run; write it only while no request is in flight.
module bitmap_spaced_expand_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tuser = kind
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bse_pkg::REQ_DATA_W-1:0]       req_tdata,  // mask_word[63:0], value[95:64]
   input  logic                                 req_tuser,  // kind[0]
   // response
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // position[30:0], data[62:31], need_word[63], values_used[94:64], zero[95]
   output logic [bse_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [bse_pkg::RSP_USER_W-1:0]       rsp_tuser,  // write_valid[0], status[2:1]
   // register write: total_bits
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bse_pkg::ROW_W-1:0]            csr_data
);
   import bse_pkg::*;

   logic    stage_valid;
   req_type stage_req;
   req_type req_word;
   logic    advance;
   logic    accept;
   rsp_type step_rsp;
   rsp_type rsp_ff,       rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Unpack the request
   always_comb begin
      req_word.kind      = kind_type'(req_tuser);
      req_word.mask_word = req_tdata[ROWS_PER_WORD-1:0];
      req_word.value     = req_tdata[ROWS_PER_WORD +: VALUE_W];
   end

   // Move a request into the result register when it has room
   assign advance    = stage_valid & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~stage_valid | advance;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   bse_req_stage u_req_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .req_in  (req_word),
      .drain   (advance),
      .valid   (stage_valid),
      .req_out (stage_req)
   );

   bse_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .req       (stage_req),
      .csr_write (csr_valid & csr_ready),
      .csr_value (csr_data),
      .rsp       (step_rsp)
   );

   // Result register
   always_comb begin
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);
      rsp_in       = advance ? step_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Pack the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.values_used, rsp_ff.need_word, rsp_ff.data, rsp_ff.position};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.write_valid};

   // Back-pressure only when both stages are full and the response is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && stage_valid && !rsp_tready)
      else $error("request stalled without a full pipeline");

   // A scatter write always carries status ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.write_valid |-> rsp_ff.status == ST_OK)
      else $error("write with non-ok status");

   // A value without a pending bit writes nothing and leaves nothing pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.status == ST_NO_BIT |-> !rsp_ff.write_valid && rsp_ff.need_word)
      else $error("bad response for value without pending bit");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_spaced_expand_top: a directed table, then random
// word/value streams under random stalls. Depends on bse_pkg and the RTL top level.
module tb;
   import bse_pkg::*;

   // one expectation typed into the directed table, or none
   typedef struct {
      bit      typed;
      rsp_type rsp;
   } fixed_rsp_type;

   typedef struct {
      bit            is_cfg;
      kind_type      kind;
      logic [63:0]   word;
      logic [31:0]   value;
      fixed_rsp_type fixed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // mask_word[63:0], value[95:64]
   logic                  req_tuser = 1'b0; // kind[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // position[30:0], data[62:31], need_word[63], values_used[94:64], zero[95]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;         // write_valid[0], status[2:1]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ROW_W-1:0]      csr_data = '0;

   // scatter model state and its copy of total_bits
   logic [30:0] total_cfg = '0;
   logic [63:0] pend_bits = '0;
   logic [31:0] word_base = '0;
   logic [31:0] next_base = '0;
   logic [30:0] placed    = '0;

   rsp_type       scatter_q[$];
   fixed_rsp_type fixed_q[$];
   stim_row_type  stim_rows[$];
   int unsigned   mismatches = 0;
   int unsigned   burst_left = 0;

   bitmap_spaced_expand_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // restart the run with a new length
   function automatic void load_total(input logic [30:0] total);
      total_cfg = total;
      pend_bits = '0;
      word_base = '0;
      next_base = '0;
      placed    = '0;
   endfunction

   // predict the response to one request and advance the scatter state
   function automatic rsp_type expand_step(input kind_type k, input logic [63:0] w,
                                           input logic [31:0] v);
      rsp_type     r;
      logic [31:0] left;
      int          idx;
      r = '0;
      r.status = ST_OK;
      if (k == KIND_WORD) begin
         if (next_base >= {1'b0, total_cfg}) begin
            r.status = ST_BEYOND;
         end else begin
            left = {1'b0, total_cfg} - next_base;
            // clear rows past the end of the bitmap
            if (left < ROWS_PER_WORD) begin
               w = w & ((64'd1 << left) - 64'd1);
            end
            if (pend_bits != '0) begin
               r.status = ST_DROPPED;
            end
            pend_bits = w;
            word_base = next_base;
            next_base = next_base + ROWS_PER_WORD;
         end
      end else if (pend_bits == '0) begin
         r.status = ST_NO_BIT;
      end else begin
         idx = 0;
         for (int i = ROWS_PER_WORD - 1; i >= 0; i--) begin
            if (pend_bits[i]) begin
               idx = i;
            end
         end
         r.write_valid = 1'b1;
         r.position    = ROW_W'(word_base + 32'(idx));
         r.data        = v;
         pend_bits     = pend_bits & (pend_bits - 64'd1);
         placed        = placed + 31'd1;
      end
      r.need_word   = (pend_bits == '0);
      r.values_used = placed;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // receiver: ready follows a repeating 16-bit pattern that changes now and then
   logic [15:0] ready_pattern = '1;
   logic [3:0]  pattern_bit   = '0;
   int unsigned pattern_left  = 0;

   always @(posedge clock) begin
      if (pattern_left == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= 16'($urandom) | 16'h0001;
            2: ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h8001;
            default: ready_pattern <= 16'($urandom) | 16'($urandom);
         endcase
         pattern_left <= $urandom_range(16, 160);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      pattern_bit <= pattern_bit + 4'd1;
      rsp_tready  <= ready_pattern[pattern_bit];
   end

   // predict on every accepted request, compare every accepted response
   always @(posedge clock) begin
      rsp_type       want;
      rsp_type       got;
      fixed_rsp_type fixed;
      if (reset) begin
         load_total('0);
      end else begin
         if (csr_valid && csr_ready) begin
            load_total(csr_data);
         end
         if (req_tvalid && req_tready) begin
            want  = expand_step(kind_type'(req_tuser), req_tdata[63:0], req_tdata[95:64]);
            fixed = fixed_q.pop_front();
            if (fixed.typed) begin
               want = fixed.rsp;
            end
            scatter_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.write_valid = rsp_tuser[0];
            got.status      = status_type'(rsp_tuser[2:1]);
            got.position    = rsp_tdata[30:0];
            got.data        = rsp_tdata[62:31];
            got.need_word   = rsp_tdata[63];
            got.values_used = rsp_tdata[94:64];
            if (scatter_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual 0x%0h / 0x%0h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = scatter_q.pop_front();
               check_field("write_valid", want.write_valid, got.write_valid);
               check_field("position", want.position, got.position);
               check_field("data", want.data, got.data);
               check_field("need_word", want.need_word, got.need_word);
               check_field("values_used", want.values_used, got.values_used);
               check_field("status", want.status, got.status);
            end
         end
      end
   end

   // send one request; the sender idles between bursts of random length
   task automatic send_request(input kind_type k, input logic [63:0] w, input logic [31:0] v,
                               input fixed_rsp_type fixed);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      fixed_q.push_back(fixed);
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {v, w};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every response is back, then write total_bits
   task automatic write_total_bits(input logic [30:0] total);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scatter_q.size() != 0);
      csr_valid <= 1'b1;
      csr_data  <= total;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic typed_row(input kind_type k, input logic [63:0] w, input logic [31:0] v,
                            input bit wv, input int unsigned pos, input logic [31:0] d,
                            input bit nw, input int unsigned used, input status_type st);
      stim_row_type row;
      row.is_cfg      = 1'b0;
      row.kind        = k;
      row.word        = w;
      row.value       = v;
      row.fixed.typed = 1'b1;
      row.fixed.rsp   = '{write_valid: wv, position: ROW_W'(pos), data: d, need_word: nw,
                          values_used: ROW_W'(used), status: st};
      stim_rows.push_back(row);
   endtask

   task automatic plain_row(input kind_type k, input logic [63:0] w, input logic [31:0] v);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.kind   = k;
      row.word   = w;
      row.value  = v;
      row.fixed  = '{typed: 1'b0, rsp: '0};
      stim_rows.push_back(row);
   endtask

   task automatic cfg_row(input logic [30:0] total);
      stim_row_type row;
      row.is_cfg = 1'b1;
      row.kind   = KIND_WORD;
      row.word   = '0;
      row.value  = {1'b0, total};
      row.fixed  = '{typed: 1'b0, rsp: '0};
      stim_rows.push_back(row);
   endtask

   // random word streams: mostly a word followed by a value per set bit
   task automatic run_phase(input logic [30:0] total, input int unsigned budget);
      fixed_rsp_type none;
      logic [63:0]   w;
      logic [31:0]   gen_base;
      int unsigned   useful;
      int unsigned   beyond;
      int unsigned   n;
      none     = '{typed: 1'b0, rsp: '0};
      gen_base = '0;
      useful   = 0;
      beyond   = 0;
      write_total_bits(total);
      while (useful < budget && beyond < 6) begin
         if ($urandom_range(0, 99) < 6) begin
            // lone value
            send_request(KIND_VALUE, {$urandom, $urandom}, $urandom, none);
            useful++;
         end else begin
            case ($urandom_range(0, 5))
               0: w = {$urandom, $urandom};
               1: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
               2: w = '1;
               3: w = '0;
               4: w = 64'd1 << $urandom_range(0, 63);
               default: w = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
            if (gen_base < {1'b0, total}) begin
               gen_base += ROWS_PER_WORD;
               useful++;
            end else begin
               beyond++;
            end
            send_request(KIND_WORD, w, $urandom, none);
            n = $countones(w);
            case ($urandom_range(0, 15))
               0: n = n + 1;
               1: n = (n > 0) ? n - 1 : 0;
               2: n = $urandom_range(0, n);
               3: n = 0;
               default: ;
            endcase
            repeat (n) begin
               send_request(KIND_VALUE, {$urandom, $urandom}, $urandom, none);
               useful++;
            end
         end
      end
   endtask

   initial begin
      // after reset: nothing is valid yet
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 1, 0, ST_BEYOND);
      typed_row(KIND_VALUE, '0, '0, 0, 0, 0, 1, 0, ST_NO_BIT);
      // longest bitmap: both end bits, then an empty word and a dropped one
      cfg_row(31'h7FFF_FFFF);
      typed_row(KIND_WORD, 64'h8000_0000_0000_0001, '0, 0, 0, 0, 0, 0, ST_OK);
      typed_row(KIND_VALUE, '0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 0, 1, ST_OK);
      typed_row(KIND_VALUE, '1, 32'h0, 1, 63, 32'h0, 1, 2, ST_OK);
      typed_row(KIND_VALUE, '0, 32'h1234_5678, 0, 0, 0, 1, 2, ST_NO_BIT);
      typed_row(KIND_WORD, '0, '1, 0, 0, 0, 1, 2, ST_OK);
      plain_row(KIND_WORD, '1, '0);
      typed_row(KIND_WORD, 64'h1, '0, 0, 0, 0, 0, 2, ST_DROPPED);
      typed_row(KIND_VALUE, '0, 32'hA5A5_A5A5, 1, 192, 32'hA5A5_A5A5, 1, 3, ST_OK);
      // one-row bitmap
      cfg_row(31'd1);
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 0, 0, ST_OK);
      typed_row(KIND_VALUE, '0, 32'd7, 1, 0, 32'd7, 1, 1, ST_OK);
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 1, 1, ST_BEYOND);
      // partial last word keeps row 99 only
      cfg_row(31'd100);
      plain_row(KIND_WORD, '0, '0);
      plain_row(KIND_WORD, 64'hF000_0018_0000_0000, '0);
      typed_row(KIND_VALUE, '0, 32'd5, 1, 99, 32'd5, 1, 1, ST_OK);
      typed_row(KIND_VALUE, '0, 32'd6, 0, 0, 0, 1, 1, ST_NO_BIT);
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 1, 1, ST_BEYOND);
      // beyond wins over dropped bits
      cfg_row(31'd64);
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 0, 0, ST_OK);
      typed_row(KIND_WORD, '1, '0, 0, 0, 0, 0, 0, ST_BEYOND);
      plain_row(KIND_VALUE, '0, 32'd9);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            write_total_bits(stim_rows[i].value[30:0]);
         end else begin
            send_request(stim_rows[i].kind, stim_rows[i].word, stim_rows[i].value,
                         stim_rows[i].fixed);
         end
      end

      run_phase(31'h7FFF_FFFF, 200);
      run_phase(31'($urandom_range(65, 900)), 200);
      run_phase(31'd64, 200);
      run_phase(31'($urandom_range(1, 63)), 200);
      run_phase(31'd0, 25);
      run_phase(31'($urandom_range(900, 4000)), 200);
      run_phase(31'($urandom), 200);
      run_phase(31'($urandom_range(65, 900)), 200);
      run_phase(31'h7FFF_FFFF, 200);

      // drain, then give stray responses a chance to show up
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scatter_q.size() != 0);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
